>>> rtl/s128_pkg.sv
// ----------------------------------------------------------------------------
// s128_pkg: shared types and codes for the 128-bit signed ALU.
// Holds the request and result payloads, operation codes and the front to
// back handoff type.
// ----------------------------------------------------------------------------
`default_nettype none

package s128_pkg;

    localparam int unsigned Width = 128;
    localparam int unsigned OpW   = 5;

    localparam logic [OpW-1:0] OP_ADD = 5'd0;
    localparam logic [OpW-1:0] OP_SUB = 5'd1;
    localparam logic [OpW-1:0] OP_MUL = 5'd2;
    localparam logic [OpW-1:0] OP_DIV = 5'd3;
    localparam logic [OpW-1:0] OP_MOD = 5'd4;
    localparam logic [OpW-1:0] OP_AND = 5'd5;
    localparam logic [OpW-1:0] OP_OR  = 5'd6;
    localparam logic [OpW-1:0] OP_XOR = 5'd7;
    localparam logic [OpW-1:0] OP_NOT = 5'd8;
    localparam logic [OpW-1:0] OP_SHL = 5'd9;
    localparam logic [OpW-1:0] OP_SHR = 5'd10;
    localparam logic [OpW-1:0] OP_ROL = 5'd11;
    localparam logic [OpW-1:0] OP_ROR = 5'd12;
    localparam logic [OpW-1:0] OP_LT  = 5'd13;
    localparam logic [OpW-1:0] OP_LE  = 5'd14;
    localparam logic [OpW-1:0] OP_GT  = 5'd15;
    localparam logic [OpW-1:0] OP_GE  = 5'd16;
    localparam logic [OpW-1:0] OP_EQ  = 5'd17;

    // Class of work chosen by the front end.
    localparam logic [1:0] CLS_SIMPLE = 2'd0;
    localparam logic [1:0] CLS_MUL    = 2'd1;
    localparam logic [1:0] CLS_DIV    = 2'd2;

    typedef struct packed {
        logic [4:0]  operation;
        logic [63:0] a_hi;
        logic [63:0] a_lo;
        logic [63:0] b_hi;
        logic [63:0] b_lo;
    } t_req;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
        logic        compare_true;
    } t_res;

    // Classified request between front and back end.
    typedef struct packed {
        logic [1:0]   cls;
        logic         want_mod;
        logic         neg_q;
        logic         neg_r;
        logic         dzero;
        logic [127:0] ua;
        logic [127:0] ub;
        t_res         simple;
    } t_job;

endpackage

`default_nettype wire

>>> rtl/s128_front.sv
// ----------------------------------------------------------------------------
// s128_front: request classifier.
// Computes the simple operations, passes the raw operands on for multiply,
// prepares magnitudes for divide, then hands a job to a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module s128_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire s128_pkg::t_req   i_req,
    input  wire logic             i_push,
    output logic                  o_full,
    output s128_pkg::t_job        o_job,
    output logic                  o_job_vld,
    input  wire logic             i_job_rdy
);

    s128_pkg::t_job r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    s128_pkg::t_job n_job;

    logic [127:0] a, b, na, nb, sum, dif, shl_v, shr_v, rl_v, rr_v;
    logic [6:0]   rot;
    logic         bneg, big, slt_ab, slt_ba;

    // Classify and compute the simple operations.
    always_comb begin
        a      = {i_req.a_hi, i_req.a_lo};
        b      = {i_req.b_hi, i_req.b_lo};
        na     = ~a + 128'd1;
        nb     = ~b + 128'd1;
        sum    = a + b;
        dif    = a - b;
        bneg   = b[127];
        big    = (b[127:7] != 121'd0);
        rot    = b[6:0];
        shl_v  = a << rot;
        shr_v  = a >> rot;
        rl_v   = (a << rot) | (a >> (8'd128 - {1'b0, rot}));
        rr_v   = (a >> rot) | (a << (8'd128 - {1'b0, rot}));
        slt_ab = (a[127] != b[127]) ? a[127] : (a < b);
        slt_ba = (a[127] != b[127]) ? b[127] : (b < a);

        n_job          = '0;
        n_job.ua       = a[127] ? na : a;
        n_job.ub       = b[127] ? nb : b;
        n_job.neg_q    = a[127] ^ b[127];
        n_job.neg_r    = a[127];
        n_job.dzero    = (b == 128'd0);
        n_job.want_mod = (i_req.operation == s128_pkg::OP_MOD);
        n_job.cls      = s128_pkg::CLS_SIMPLE;
        case (i_req.operation)
            s128_pkg::OP_ADD: {n_job.simple.result_hi, n_job.simple.result_lo} = sum;
            s128_pkg::OP_SUB: {n_job.simple.result_hi, n_job.simple.result_lo} = dif;
            s128_pkg::OP_MUL: begin
                n_job.cls = s128_pkg::CLS_MUL;
                n_job.ua  = a;
                n_job.ub  = b;
            end
            s128_pkg::OP_DIV, s128_pkg::OP_MOD: n_job.cls = s128_pkg::CLS_DIV;
            s128_pkg::OP_AND: {n_job.simple.result_hi, n_job.simple.result_lo} = a & b;
            s128_pkg::OP_OR:  {n_job.simple.result_hi, n_job.simple.result_lo} = a | b;
            s128_pkg::OP_XOR: {n_job.simple.result_hi, n_job.simple.result_lo} = a ^ b;
            s128_pkg::OP_NOT: {n_job.simple.result_hi, n_job.simple.result_lo} = ~a;
            s128_pkg::OP_SHL: {n_job.simple.result_hi, n_job.simple.result_lo} =
                bneg ? a : (big ? 128'd0 : shl_v);
            s128_pkg::OP_SHR: {n_job.simple.result_hi, n_job.simple.result_lo} =
                bneg ? a : (big ? 128'd0 : shr_v);
            s128_pkg::OP_ROL: {n_job.simple.result_hi, n_job.simple.result_lo} =
                (bneg || rot == 7'd0) ? a : rl_v;
            s128_pkg::OP_ROR: {n_job.simple.result_hi, n_job.simple.result_lo} =
                (bneg || rot == 7'd0) ? a : rr_v;
            s128_pkg::OP_LT: n_job.simple.compare_true = slt_ab;
            s128_pkg::OP_LE: n_job.simple.compare_true = !slt_ba;
            s128_pkg::OP_GT: n_job.simple.compare_true = slt_ba;
            s128_pkg::OP_GE: n_job.simple.compare_true = !slt_ab;
            s128_pkg::OP_EQ: n_job.simple.compare_true = (a == b);
            default: n_job.simple = '0;
        endcase
    end

    logic do_push, do_pop;
    assign o_full    = (r_cnt == 2'd2);
    assign o_job_vld = (r_cnt != 2'd0);
    assign o_job     = r_q[r_rp];
    assign do_push   = i_push && !o_full;
    assign do_pop    = o_job_vld && i_job_rdy;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= n_job;
        end
    end

    // Queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

`default_nettype wire

>>> rtl/s128_back.sv
// ----------------------------------------------------------------------------
// s128_back: execution unit.
// Simple results go straight to the output register, the multiply runs through 32x32 partial
// products one per cycle, and the divide is restoring, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module s128_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire s128_pkg::t_job   i_job,
    input  wire logic             i_job_vld,
    output logic                  o_job_rdy,
    output s128_pkg::t_res        o_res,
    output logic                  o_res_vld,
    input  wire logic             i_res_rdy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]   r_st;
    logic [6:0]   r_cnt;
    logic [4:0]   r_mi;
    logic [127:0] r_x, r_y, r_acc, r_rem;
    logic         r_mod, r_nq, r_nr;
    logic [63:0]  r_pp;
    s128_pkg::t_res r_out;
    logic         r_ovld;

    logic         out_free;
    logic [1:0]   mi, mj;
    logic [31:0]  ma, mb;
    logic [128:0] trial;
    logic [127:0] rsh, qres, rres;

    assign out_free  = !r_ovld || i_res_rdy;
    assign o_job_rdy = (r_st == ST_IDLE) && out_free;
    assign o_res     = r_out;
    assign o_res_vld = r_ovld;

    // Partial product selection: r_mi walks all sixteen word pairs in order.
    always_comb begin
        mi = r_mi[3:2];
        mj = r_mi[1:0];
        ma = r_x[{mi, 5'd0} +: 32];
        mb = r_y[{mj, 5'd0} +: 32];
        rsh   = {r_rem[126:0], r_acc[127]};
        trial = {1'b0, rsh} - {1'b0, r_y};
        qres  = r_nq ? (~{r_acc[126:0], !trial[128]} + 128'd1) : {r_acc[126:0], !trial[128]};
        rres  = trial[128] ? rsh : trial[127:0];
        rres  = r_nr ? (~rres + 128'd1) : rres;
    end

    // Sequencer and datapath.
    always_ff @(posedge i_clk) begin
        r_pp <= ma * mb;
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_ovld <= 1'b0;
        end else begin
            if (r_ovld && i_res_rdy) r_ovld <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (i_job_vld && out_free) begin
                        r_x <= i_job.ua;
                        r_y <= i_job.ub;
                        r_mod <= i_job.want_mod;
                        r_nq <= i_job.neg_q;
                        r_nr <= i_job.neg_r;
                        r_acc <= '0;
                        r_rem <= '0;
                        r_mi <= 5'd0;
                        r_cnt <= 7'd0;
                        if (i_job.cls == s128_pkg::CLS_MUL) begin
                            r_st <= ST_MUL;
                        end else if (i_job.cls == s128_pkg::CLS_DIV && !i_job.dzero) begin
                            r_acc <= i_job.ua;
                            r_st  <= ST_DIV;
                        end else begin
                            r_out  <= i_job.cls == s128_pkg::CLS_DIV ? '0 : i_job.simple;
                            r_ovld <= 1'b1;
                        end
                    end
                end
                ST_MUL: begin
                    // r_pp holds the product of the pair in r_cnt[3:0] when r_cnt[4]
                    // is set. Pairs whose weight reaches 128 bits shift out.
                    if (r_cnt[4]) begin
                        r_acc <= r_acc + ({64'd0, r_pp}
                                 << {{1'b0, r_cnt[3:2]} + {1'b0, r_cnt[1:0]}, 5'd0});
                    end
                    r_cnt <= {3'b001, r_mi[3:0]};
                    if (r_mi[4]) begin
                        r_out  <= '{result_hi: r_acc[127:64] + 64'd0,
                                   result_lo: r_acc[63:0], compare_true: 1'b0};
                        r_st   <= ST_IDLE;
                        r_ovld <= 1'b1;
                    end else begin
                        r_mi <= r_mi + 5'd1;
                    end
                end
                ST_DIV: begin
                    r_rem <= trial[128] ? rsh : trial[127:0];
                    r_acc <= {r_acc[126:0], !trial[128]};
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd127) begin
                        r_out <= r_mod ? '{result_hi: rres[127:64], result_lo: rres[63:0],
                                           compare_true: 1'b0}
                                       : '{result_hi: qres[127:64], result_lo: qres[63:0],
                                           compare_true: 1'b0};
                        r_st   <= ST_IDLE;
                        r_ovld <= 1'b1;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/signed_128bit_alu.sv
// ----------------------------------------------------------------------------
// signed_128bit_alu: 128-bit signed integer ALU with queue style ports.
// Front end classifies requests into a two-entry queue; back end executes.
// ----------------------------------------------------------------------------
// A simple operation's result is registered in the back end; multiply runs
// sixteen 32x32 partial products through one multiplier; divide and modulo
// produce one quotient bit per cycle. Simple operations sustain one request
// every cycle while results are popped; the back end takes no new request
// while a multiply or divide runs. A waiting result holds off the back end.
// Synchronous active-low reset empties the request queue and result register.
`default_nettype none

module signed_128bit_alu (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire s128_pkg::t_req  i_req,
    input  wire logic            push,
    output logic                 full,
    output s128_pkg::t_res       o_res,
    output logic                 empty,
    input  wire logic            pop
);

    s128_pkg::t_job job;
    logic           job_vld, job_rdy, res_vld;

    s128_front u_front (
        .i_clk, .i_rst_n, .i_req, .i_push(push), .o_full(full),
        .o_job(job), .o_job_vld(job_vld), .i_job_rdy(job_rdy)
    );

    s128_back u_back (
        .i_clk, .i_rst_n, .i_job(job), .i_job_vld(job_vld), .o_job_rdy(job_rdy),
        .o_res, .o_res_vld(res_vld), .i_res_rdy(pop)
    );

    assign empty = !res_vld;

    // A waiting result stays until it is popped.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty) else $error("result dropped");
    // Compares produce zero data.
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.compare_true) |-> (o_res.result_hi == 64'd0
                                             && o_res.result_lo == 64'd0))
        else $error("compare with nonzero data");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 128-bit signed ALU.
// Requests go in through the push/full port and results come out through the
// empty/pop port. Each accepted request is run through a behavioral model of
// the ALU, and every popped result is checked against the oldest prediction.
// Both ports idle at random. The result side also holds off once for a long
// stretch so that the input stalls. The request side also pauses once until
// the block has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Scoreboard: predicts each ALU result and checks the popped ones in order.
    class alu_scoreboard;
        s128_pkg::t_res pending[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        // Signed divide or modulo. Both truncate toward zero.
        function logic [127:0] sdivmod(logic [127:0] a, logic [127:0] b,
                                       bit want_mod);
            logic [127:0] ua, ub, q, r;
            if (b == '0) return '0;
            ua = a[127] ? -a : a;
            ub = b[127] ? -b : b;
            q = ua / ub;
            r = ua % ub;
            if (want_mod) return a[127] ? -r : r;
            return (a[127] ^ b[127]) ? -q : q;
        endfunction

        function s128_pkg::t_res compute(s128_pkg::t_req rq);
            s128_pkg::t_res rs;
            logic [127:0] a, b, y;
            logic [255:0] dbl;
            bit           big;
            logic [6:0]   rot;
            a = {rq.a_hi, rq.a_lo};
            b = {rq.b_hi, rq.b_lo};
            y = '0;
            rs.compare_true = 1'b0;
            big = (b[127:7] != '0);
            rot = b[6:0];
            case (rq.operation)
                s128_pkg::OP_ADD: y = a + b;
                s128_pkg::OP_SUB: y = a - b;
                s128_pkg::OP_MUL: y = a * b;
                s128_pkg::OP_DIV: y = sdivmod(a, b, 1'b0);
                s128_pkg::OP_MOD: y = sdivmod(a, b, 1'b1);
                s128_pkg::OP_AND: y = a & b;
                s128_pkg::OP_OR:  y = a | b;
                s128_pkg::OP_XOR: y = a ^ b;
                s128_pkg::OP_NOT: y = ~a;
                s128_pkg::OP_SHL: y = b[127] ? a : (big ? '0 : a << b[6:0]);
                s128_pkg::OP_SHR: y = b[127] ? a : (big ? '0 : a >> b[6:0]);
                s128_pkg::OP_ROL: begin
                    dbl = {a, a} << rot;
                    y = (b[127] || rot == 7'd0) ? a : dbl[255:128];
                end
                s128_pkg::OP_ROR: begin
                    dbl = {a, a} >> rot;
                    y = (b[127] || rot == 7'd0) ? a : dbl[127:0];
                end
                s128_pkg::OP_LT: rs.compare_true = $signed(a) <  $signed(b);
                s128_pkg::OP_LE: rs.compare_true = $signed(a) <= $signed(b);
                s128_pkg::OP_GT: rs.compare_true = $signed(a) >  $signed(b);
                s128_pkg::OP_GE: rs.compare_true = $signed(a) >= $signed(b);
                s128_pkg::OP_EQ: rs.compare_true = (a == b);
                default: ;
            endcase
            rs.result_hi = y[127:64];
            rs.result_lo = y[63:0];
            return rs;
        endfunction

        function void note_request(s128_pkg::t_req rq);
            pending.push_back(compute(rq));
        endfunction

        function void check_result(s128_pkg::t_res got);
            s128_pkg::t_res exp_res;
            if (pending.size() == 0) begin
                $error("result popped with no request outstanding");
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (got.result_hi !== exp_res.result_hi) begin
                $error("result_hi expected %h actual %h", exp_res.result_hi, got.result_hi);
                errors++;
            end
            if (got.result_lo !== exp_res.result_lo) begin
                $error("result_lo expected %h actual %h", exp_res.result_lo, got.result_lo);
                errors++;
            end
            if (got.compare_true !== exp_res.compare_true) begin
                $error("compare_true expected %b actual %b",
                       exp_res.compare_true, got.compare_true);
                errors++;
            end
        endfunction
    endclass

    localparam int NUM_RANDOM = 1500;
    localparam int STALL_LIMIT = 2000;
    localparam logic [127:0] MIN_VAL = {1'b1, 127'b0};
    localparam logic [127:0] MAX_VAL = {1'b0, {127{1'b1}}};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    s128_pkg::t_req req = '0;
    logic push = 1'b0;
    logic full;
    s128_pkg::t_res o_res;
    logic empty;
    logic pop = 1'b0;

    alu_scoreboard sb = new();
    bit send_done = 0;
    bit hold_rx = 0;
    bit no_idle = 0;
    int idle_cycles = 0;

    signed_128bit_alu u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .push(push), .full(full),
        .o_res(o_res), .empty(empty), .pop(pop)
    );

    always #1 i_clk = ~i_clk;

    // Random operand with a bias toward edge values.
    function automatic logic [127:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return MIN_VAL;
            2: return MAX_VAL;
            3: return '1;
            4: return 128'($urandom_range(0, 300));
            5: return -128'($urandom_range(1, 300));
            6: return {{64{1'b0}}, $urandom, $urandom};
            default: return {$urandom, $urandom, $urandom, $urandom};
        endcase
    endfunction

    // Present one request and hold it until the block accepts it.
    task automatic send_request(logic [4:0] op, logic [127:0] a, logic [127:0] b);
        req <= {op, a, b};
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        sb.note_request({op, a, b});
    endtask

    // Drop push for idle cycles now and then.
    task automatic sender_gap();
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 27) begin
                push <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    // Request driver: a directed part, then random requests.
    initial begin
        logic [127:0] a, b;
        int op;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed part: arithmetic edge cases and every operation at least once.
        send_request(s128_pkg::OP_DIV, MIN_VAL, '1);
        send_request(s128_pkg::OP_MOD, MIN_VAL, '1);
        send_request(s128_pkg::OP_DIV, MAX_VAL, '0);
        send_request(s128_pkg::OP_MOD, -128'd7, 128'd2);
        send_request(s128_pkg::OP_DIV, -128'd7, 128'd2);
        send_request(s128_pkg::OP_ADD, MAX_VAL, 128'd1);
        send_request(s128_pkg::OP_MUL, '1, '1);
        send_request(s128_pkg::OP_SHL, '1, 128'd128);
        send_request(s128_pkg::OP_SHR, '1, -128'd3);
        send_request(s128_pkg::OP_SHL, MAX_VAL, 128'd0);
        send_request(s128_pkg::OP_SHR, MIN_VAL, 128'd127);
        send_request(s128_pkg::OP_ROL, 128'h1234_5678, {64'd1, 64'd200});
        send_request(s128_pkg::OP_ROR, 128'h1234_5678, -128'd1);
        send_request(s128_pkg::OP_ROR, 128'hF0, 128'd4);
        for (int k = 0; k <= 31; k++) begin
            if (k != s128_pkg::OP_DIV && k != s128_pkg::OP_MOD
                && (k < s128_pkg::OP_SHL || k > s128_pkg::OP_ROR)
                && k <= s128_pkg::OP_EQ + 2)
                send_request(5'(k), MIN_VAL, MAX_VAL);
        end
        // Random part. A stretch in the middle runs without idling.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            no_idle = (n >= 600 && n < 800);
            if (n == 300) begin
                // Let the block drain completely.
                push <= 1'b0;
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            sender_gap();
            op = $urandom_range(0, 99) < 5 ? $urandom_range(18, 31) : $urandom_range(0, 17);
            a = pick_operand();
            b = pick_operand();
            if (op >= s128_pkg::OP_SHL && op <= s128_pkg::OP_ROR && $urandom_range(0, 1))
                b = 128'($urandom_range(0, 140));
            send_request(5'(op), a, b);
        end
        push <= 1'b0;
        send_done = 1;
    end

    // Result side: random pop, with one long hold-off.
    initial begin
        int cnt;
        cnt = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && !empty && pop) sb.check_result(o_res);
            cnt++;
            if (cnt == 2000) hold_rx = 1;
            if (cnt == 2400) hold_rx = 0;
            pop <= !hold_rx && (no_idle || $urandom_range(0, 99) >= 27);
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || hold_rx) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // End of run.
    initial begin
        wait (send_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0 && empty)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // An unexpected extra result after the drain is caught by check_result.

endmodule

`default_nettype wire

>>> sim.f
rtl/s128_pkg.sv
rtl/s128_front.sv
rtl/s128_back.sv
rtl/signed_128bit_alu.sv
tb/tb_top.sv
